[hdl/ics_pkg.sv]
// ----------------------------------------------------------------------------
// ics_pkg
// Request and result types and command codes for the interval cover sweep.
// ----------------------------------------------------------------------------
package ics_pkg;

	localparam logic [1:0] KIND_ADD   = 2'd0;
	localparam logic [1:0] KIND_SORT  = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;
	localparam logic [1:0] KIND_CLEAR = 2'd3;

	localparam int TIME_W  = 64;
	localparam int COUNT_W = 7;

	typedef struct packed {
		logic [1:0]        kind;
		logic [TIME_W-1:0] t_begin;
		logic [TIME_W-1:0] t_end;
		logic [TIME_W-1:0] t_msg;
	} ics_req_t;

	typedef struct packed {
		logic               in_range;
		logic               overflow;
		logic [TIME_W-1:0]  next_begin;
		logic [TIME_W-1:0]  next_end;
		logic [COUNT_W-1:0] entry_count;
	} ics_rsp_t;

endpackage

[hdl/interval_cover_sweep.sv]
// ----------------------------------------------------------------------------
// interval_cover_sweep
// Interval table with merge on add, stable sort, sweeping coverage query.
// ----------------------------------------------------------------------------
// Add reads the last appended entry, then merges into it or appends; clear
// empties the table; query sweeps the cursor, then makes one pass over all
// entries; sort is an insertion sort through one memory port.
// One request at a time: the result is held until taken, then the block returns to idle.
// Reset clears count, cursor, marks and control; the stores are not cleared.
module interval_cover_sweep
	import ics_pkg::*;
#(
	parameter int TABLE_DEPTH = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  ics_req_t in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output ics_rsp_t out_data
);
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_ARD    = 4'd1; // read last appended
	localparam logic [3:0] ST_ADD    = 4'd2;
	localparam logic [3:0] ST_QRD    = 4'd3; // read cursor entry
	localparam logic [3:0] ST_QCHK   = 4'd4;
	localparam logic [3:0] ST_QPRD   = 4'd5; // read entry i for end match
	localparam logic [3:0] ST_QPCHK  = 4'd6;
	localparam logic [3:0] ST_SKEY   = 4'd7; // read key i
	localparam logic [3:0] ST_SKEYW  = 4'd8;
	localparam logic [3:0] ST_SCMPRD = 4'd9; // read j-1
	localparam logic [3:0] ST_SCMP   = 4'd10;
	localparam logic [3:0] ST_RRD    = 4'd11; // read cursor entry for result
	localparam logic [3:0] ST_RES    = 4'd12;
	localparam logic [3:0] ST_OUT    = 4'd13;

	logic [TIME_W-1:0] beg_mem [TABLE_DEPTH];
	logic [TIME_W-1:0] end_mem [TABLE_DEPTH];
	logic [TIME_W-1:0] rd_beg_q, rd_end_q;
	logic [TABLE_DEPTH-1:0] mark_q;

	logic [3:0]    state_q;
	ics_req_t      req_q;
	ics_rsp_t      rsp_q;
	logic [CW-1:0] count_q, cursor_q, last_q, i_q, j_q;
	logic [TIME_W-1:0] kb_q, ke_q;
	logic          moving_q, found_q;

	// single memory port: read address, write enable/address/data
	logic [AW-1:0]     raddr;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [TIME_W-1:0] wbeg, wend;

	always_ff @(posedge clk) begin
		if (we) begin
			beg_mem[waddr] <= wbeg;
			end_mem[waddr] <= wend;
		end
		rd_beg_q <= beg_mem[raddr];
		rd_end_q <= end_mem[raddr];
	end

	logic cur_valid;
	assign cur_valid = (cursor_q < count_q);

	always_comb begin
		raddr = AW'(0);
		we    = 1'b0;
		waddr = AW'(0);
		wbeg  = req_q.t_begin;
		wend  = req_q.t_end;
		case (state_q)
			ST_ARD:   raddr = last_q[AW-1:0];
			ST_QRD, ST_RRD: raddr = cursor_q[AW-1:0];
			ST_QPRD, ST_SKEY: raddr = i_q[AW-1:0];
			ST_SCMPRD: raddr = AW'(j_q - CW'(1));
			ST_ADD: begin
				if (count_q == '0 || last_q >= count_q
						|| req_q.t_begin > rd_end_q) begin
					we    = (count_q < CW'(TABLE_DEPTH));
					waddr = count_q[AW-1:0];
				end else begin
					we    = 1'b1;
					waddr = last_q[AW-1:0];
					wbeg  = (req_q.t_begin < rd_beg_q) ? req_q.t_begin : rd_beg_q;
					wend  = (req_q.t_end > rd_end_q) ? req_q.t_end : rd_end_q;
				end
			end
			ST_SCMP: begin
				we    = 1'b1;
				waddr = j_q[AW-1:0];
				if (j_q != '0 && rd_beg_q > kb_q) begin
					wbeg = rd_beg_q;
					wend = rd_end_q;
				end else begin
					wbeg = kb_q;
					wend = ke_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			cursor_q <= '0;
			last_q   <= '0;
			mark_q   <= '0;
			i_q      <= '0;
			j_q      <= '0;
			moving_q <= 1'b0;
			found_q  <= 1'b0;
			req_q    <= '0;
			rsp_q    <= '0;
			kb_q     <= '0;
			ke_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						req_q   <= in_data;
						found_q <= 1'b0;
						rsp_q.in_range <= 1'b0;
						rsp_q.overflow <= 1'b0;
						i_q <= CW'(1);
						case (in_data.kind)
							KIND_ADD:   state_q <= ST_ARD;
							KIND_SORT:  state_q <= ST_SKEY;
							KIND_QUERY: state_q <= ST_QRD;
							default: begin
								count_q  <= '0;
								cursor_q <= '0;
								last_q   <= '0;
								mark_q   <= '0;
								state_q  <= ST_RRD;
							end
						endcase
					end
				end
				ST_ARD: state_q <= ST_ADD;
				ST_ADD: begin
					if (count_q == '0 || last_q >= count_q
							|| req_q.t_begin > rd_end_q) begin
						if (count_q >= CW'(TABLE_DEPTH)) begin
							rsp_q.overflow <= 1'b1;
						end else begin
							mark_q[count_q[AW-1:0]] <= 1'b0;
							last_q  <= count_q;
							count_q <= count_q + CW'(1);
						end
					end
					state_q <= ST_RRD;
				end
				ST_QRD: begin
					// end-match pass always starts at entry 0
					i_q     <= '0;
					state_q <= cur_valid ? ST_QCHK : ST_QPRD;
				end
				ST_QCHK: begin
					if (req_q.t_msg >= rd_beg_q) begin
						mark_q[cursor_q[AW-1:0]] <= 1'b1;
						cursor_q <= cursor_q + CW'(1);
						state_q  <= ST_QRD;
					end else begin
						state_q <= ST_QPRD;
					end
					i_q <= '0;
				end
				ST_QPRD: begin
					if (i_q >= count_q) begin
						rsp_q.in_range <= found_q;
						state_q <= ST_RRD;
					end else begin
						state_q <= ST_QPCHK;
					end
				end
				ST_QPCHK: begin
					if (mark_q[i_q[AW-1:0]]) begin
						found_q <= 1'b1;
						if (rd_end_q == req_q.t_msg) mark_q[i_q[AW-1:0]] <= 1'b0;
					end
					i_q <= i_q + CW'(1);
					state_q <= ST_QPRD;
				end
				ST_SKEY: begin
					if (i_q >= count_q) begin
						cursor_q <= '0;
						mark_q   <= '0;
						state_q  <= ST_RRD;
					end else begin
						state_q <= ST_SKEYW;
					end
				end
				ST_SKEYW: begin
					kb_q     <= rd_beg_q;
					ke_q     <= rd_end_q;
					moving_q <= (last_q == i_q);
					j_q      <= i_q;
					state_q  <= ST_SCMPRD;
				end
				ST_SCMPRD: state_q <= ST_SCMP;
				ST_SCMP: begin
					if (j_q != '0 && rd_beg_q > kb_q) begin
						if (!moving_q && last_q == j_q - CW'(1)) last_q <= j_q;
						j_q     <= j_q - CW'(1);
						state_q <= ST_SCMPRD;
					end else begin
						if (moving_q) last_q <= j_q;
						i_q     <= i_q + CW'(1);
						state_q <= ST_SKEY;
					end
				end
				ST_RRD: state_q <= ST_RES;
				ST_RES: begin
					rsp_q.next_begin  <= cur_valid ? rd_beg_q : '0;
					rsp_q.next_end    <= cur_valid ? rd_end_q : '0;
					rsp_q.entry_count <= COUNT_W'(count_q);
					state_q <= ST_OUT;
				end
				ST_OUT: if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_data  = rsp_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH)) else $error("count above depth");
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= count_q || state_q == ST_ADD || state_q == ST_OUT
		|| state_q == ST_IDLE || state_q == ST_RRD || state_q == ST_RES
		|| state_q == ST_ARD) else $error("cursor beyond count");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.overflow |-> count_q == CW'(TABLE_DEPTH))
		else $error("overflow without full table");
endmodule

[tb/interval_cover_sweep_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// interval_cover_sweep_tb
// Drives add, sort, query and clear requests with random gaps and receiver
// stalls, predicts every result from a local copy of the interval table and
// compares each result field by field in order.
// ----------------------------------------------------------------------------
module interval_cover_sweep_tb;
	import ics_pkg::*;

	localparam int DEPTH = 64;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	ics_req_t in_data;
	logic     out_valid;
	logic     out_ready;
	ics_rsp_t out_data;

	interval_cover_sweep #(.TABLE_DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// predictor state
	logic [63:0] tbl_begin [DEPTH] = '{default: '0};
	logic [63:0] tbl_end [DEPTH] = '{default: '0};
	bit          tbl_mark [DEPTH] = '{default: 1'b0};
	int          tbl_count = 0;
	int          tbl_cursor = 0;
	int          tbl_last = 0;

	ics_req_t pending_reqs[$];
	ics_rsp_t expected_rsps[$];
	int       mismatches = 0;
	int       send_idle_pct;
	int       recv_idle_pct;
	int       hold_cycles;
	bit       hold_go = 1'b0;
	bit       hold_used;

	function automatic ics_rsp_t predict_result(ics_req_t r);
		ics_rsp_t    p;
		logic [63:0] kb, ke;
		bit          moving;
		int          j;
		p = '0;
		case (r.kind)
			KIND_ADD: begin
				if (tbl_count == 0 || tbl_last >= tbl_count
						|| r.t_begin > tbl_end[tbl_last]) begin
					if (tbl_count >= DEPTH) begin
						p.overflow = 1'b1;
					end else begin
						tbl_begin[tbl_count] = r.t_begin;
						tbl_end[tbl_count] = r.t_end;
						tbl_mark[tbl_count] = 0;
						tbl_last = tbl_count;
						tbl_count++;
					end
				end else begin
					if (r.t_begin < tbl_begin[tbl_last]) tbl_begin[tbl_last] = r.t_begin;
					if (r.t_end > tbl_end[tbl_last]) tbl_end[tbl_last] = r.t_end;
				end
			end
			KIND_SORT: begin
				for (int i = 1; i < tbl_count; i++) begin
					kb = tbl_begin[i];
					ke = tbl_end[i];
					moving = (tbl_last == i);
					j = i;
					while (j > 0 && tbl_begin[j-1] > kb) begin
						tbl_begin[j] = tbl_begin[j-1];
						tbl_end[j] = tbl_end[j-1];
						if (!moving && tbl_last == j - 1) tbl_last = j;
						j--;
					end
					tbl_begin[j] = kb;
					tbl_end[j] = ke;
					if (moving) tbl_last = j;
				end
				tbl_cursor = 0;
				foreach (tbl_mark[i]) tbl_mark[i] = 0;
			end
			KIND_QUERY: begin
				while (tbl_cursor < tbl_count && r.t_msg >= tbl_begin[tbl_cursor]) begin
					tbl_mark[tbl_cursor] = 1;
					tbl_cursor++;
				end
				for (int i = 0; i < tbl_count; i++)
					if (tbl_mark[i]) p.in_range = 1'b1;
				for (int i = 0; i < tbl_count; i++)
					if (tbl_mark[i] && tbl_end[i] == r.t_msg) tbl_mark[i] = 0;
			end
			default: begin
				tbl_count = 0;
				tbl_cursor = 0;
				tbl_last = 0;
				foreach (tbl_mark[i]) tbl_mark[i] = 0;
			end
		endcase
		if (tbl_cursor < tbl_count) begin
			p.next_begin = tbl_begin[tbl_cursor];
			p.next_end = tbl_end[tbl_cursor];
		end
		p.entry_count = tbl_count[COUNT_W-1:0];
		return p;
	endfunction

	function automatic logic [63:0] rand_time();
		logic [63:0] t;
		case ($urandom_range(0, 5))
			0: t = '0;
			1: t = '1;
			2: t = {$urandom, $urandom};
			default: t = 64'($urandom_range(0, 60));
		endcase
		return t;
	endfunction

	task automatic push_req(logic [1:0] k, logic [63:0] b, logic [63:0] e, logic [63:0] m);
		ics_req_t r;
		r.kind = k;
		r.t_begin = b;
		r.t_end = e;
		r.t_msg = m;
		pending_reqs.insert(pending_reqs.size(), r);
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else if (!in_valid || in_ready) begin
			if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				in_data <= pending_reqs.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// predict on acceptance
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			expected_rsps.insert(expected_rsps.size(), predict_result(in_data));
	end

	// receiver stall, with one long hold-off when requested
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_cycles <= 0;
			hold_used <= 1'b0;
		end else if (hold_go && !hold_used) begin
			hold_used <= 1'b1;
			hold_cycles <= 400;
			out_ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		ics_rsp_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_rsps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", out_data);
			end else begin
				want = expected_rsps.pop_front();
				if (out_data.in_range !== want.in_range || out_data.overflow !== want.overflow
						|| out_data.next_begin !== want.next_begin
						|| out_data.next_end !== want.next_end
						|| out_data.entry_count !== want.entry_count) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %p, got %p", want, out_data);
				end
			end
		end
	end

	initial begin
		#20000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		logic [63:0] b;
		int          k;
		send_idle_pct = 33;
		recv_idle_pct = 45;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty-table commands, extremes, merge, equal begins, empty interval
		push_req(KIND_QUERY, '0, '0, '1);
		push_req(KIND_SORT, '0, '0, '0);
		push_req(KIND_ADD, 64'd10, 64'd20, '0);
		push_req(KIND_ADD, 64'd15, 64'd30, '0);
		push_req(KIND_ADD, 64'd5, 64'd8, '0);
		push_req(KIND_ADD, 64'd40, 64'd35, '0);
		push_req(KIND_ADD, 64'd5, 64'd6, '0);
		push_req(KIND_ADD, '1, '1, '0);
		push_req(KIND_ADD, '0, '0, '0);
		push_req(KIND_SORT, '0, '0, '0);
		push_req(KIND_QUERY, '0, '0, 64'd5);
		push_req(KIND_QUERY, '0, '0, 64'd8);
		push_req(KIND_ADD, 64'd2, 64'd50, '0);
		push_req(KIND_QUERY, '0, '0, 64'd30);
		push_req(KIND_QUERY, '0, '0, '1);
		push_req(KIND_QUERY, '0, '0, '1);
		push_req(KIND_CLEAR, '0, '0, '0);
		push_req(KIND_QUERY, '0, '0, 64'd1);
		// fill past full, the last add merges
		for (int i = 0; i < DEPTH + 2; i++)
			push_req(KIND_ADD, 64'(4 * i), 64'(4 * i + 1), '0);
		push_req(KIND_ADD, 64'(4 * DEPTH + 4), 64'(4 * DEPTH + 8), '0);
		push_req(KIND_ADD, 64'(4 * DEPTH - 3), 64'(4 * DEPTH + 9), '0);
		push_req(KIND_SORT, '0, '0, '0);
		push_req(KIND_QUERY, '0, '0, 64'd100);
		// receiver holds off while the sender keeps offering
		wait (pending_reqs.size() < 20);
		hold_go = 1'b1;

		for (int n = 0; n < 500; n++) begin
			if (n == 170) begin
				wait (pending_reqs.size() == 0);
				send_idle_pct = 45;
				recv_idle_pct = 33;
			end else if (n == 340) begin
				wait (pending_reqs.size() == 0);
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			k = $urandom_range(0, 99);
			if (k < 50) begin
				b = rand_time();
				push_req(KIND_ADD, b, ($urandom_range(0, 7) == 0) ? rand_time()
					: b + 64'($urandom_range(0, 8)), rand_time());
			end else if (k < 58) begin
				push_req(KIND_SORT, rand_time(), rand_time(), rand_time());
			end else if (k < 96) begin
				push_req(KIND_QUERY, rand_time(), rand_time(), rand_time());
			end else begin
				push_req(KIND_CLEAR, rand_time(), rand_time(), rand_time());
			end
		end
		wait (pending_reqs.size() == 0);
		@(posedge clk);
		while (in_valid) @(posedge clk);
		wait (expected_rsps.size() == 0);
		repeat (50) @(posedge clk);
		if (mismatches == 0 && expected_rsps.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[files.f]
hdl/ics_pkg.sv
hdl/interval_cover_sweep.sv
tb/interval_cover_sweep_tb.sv
